// ===== rtl/pidaw_pkg.sv =====
// Shared types and constants for the anti-windup PID controller.
// Holds the Q8.8 data widths and the configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned ErrWidth  = DataWidth + 1;
  localparam int unsigned SumWidth  = DataWidth + 2;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I        = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_INTEGRAL_LOW  = 3'd3,
    CFG_INTEGRAL_HIGH = 3'd4,
    CFG_OUTPUT_LOW    = 3'd5,
    CFG_OUTPUT_HIGH   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_STEP  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

endpackage

`default_nettype wire

// ===== rtl/pid_controller_antiwindup.sv =====
// Anti-windup PID controller, signed Q8.8, conditional integration.
// Pipeline: input register, then result register. Throughput: one item per
// cycle unless out_ready_i stalls the result register; the state update and
// all three gain products sit in the single stage between the registers.
// Reset: gains clear to zero, limits open to the full 16-bit range, state zero.
// Depends on pidaw_pkg and pidaw_scale.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_antiwindup import pidaw_pkg::*; #(
  parameter logic signed [15:0] P_TERM_MIN = 16'sh8000,
  parameter logic signed [15:0] P_TERM_MAX = 16'sh7fff,
  parameter logic signed [15:0] D_TERM_MIN = 16'sh8000,
  parameter logic signed [15:0] D_TERM_MAX = 16'sh7fff
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [DataWidth-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic signed [DataWidth-1:0] target_i,
  input  logic signed [DataWidth-1:0] measured_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] command_o
);

  function automatic logic signed [SumWidth-1:0] clamp(
    input logic signed [SumWidth-1:0] v,
    input logic signed [SumWidth-1:0] lo,
    input logic signed [SumWidth-1:0] hi
  );
    logic signed [SumWidth-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic signed [DataWidth-1:0] sat_data(
    input logic signed [DataWidth:0] v
  );
    logic signed [DataWidth-1:0] r;
    if (v[DataWidth] != v[DataWidth-1]) begin
      r = v[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
    end else begin
      r = v[DataWidth-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [DataWidth-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DataWidth-1:0] int_low_q, int_high_q, out_low_q, out_high_q;

  // Input stage
  logic                        in_valid_q;
  logic                        kind_q;
  logic signed [DataWidth-1:0] target_q, measured_q;

  // Controller state
  logic signed [ErrWidth-1:0]  last_error_q, last_error_d;
  logic signed [DataWidth-1:0] integral_q, integral_d;
  logic signed [DataWidth-1:0] last_cmd_q, last_cmd_d;

  // Result stage
  logic                        out_valid_q;
  logic signed [DataWidth-1:0] command_q;

  logic                        advance;
  logic signed [ErrWidth-1:0]  error;
  logic signed [ErrWidth:0]    error_diff;
  logic signed [DataWidth-1:0] p_raw, i_raw, d_raw;
  logic signed [DataWidth-1:0] p_term, d_term;
  logic signed [DataWidth-1:0] int_sum;
  logic signed [SumWidth-1:0]  total;
  logic                        in_band;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign command_o   = command_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      int_low_q  <= {1'b1, {(DataWidth-1){1'b0}}};
      int_high_q <= {1'b0, {(DataWidth-1){1'b1}}};
      out_low_q  <= {1'b1, {(DataWidth-1){1'b0}}};
      out_high_q <= {1'b0, {(DataWidth-1){1'b1}}};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:        gain_p_q   <= cfg_data_i;
        CFG_GAIN_I:        gain_i_q   <= cfg_data_i;
        CFG_GAIN_D:        gain_d_q   <= cfg_data_i;
        CFG_INTEGRAL_LOW:  int_low_q  <= cfg_data_i;
        CFG_INTEGRAL_HIGH: int_high_q <= cfg_data_i;
        CFG_OUTPUT_LOW:    out_low_q  <= cfg_data_i;
        CFG_OUTPUT_HIGH:   out_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q     <= kind_i;
      target_q   <= target_i;
      measured_q <= measured_i;
    end
  end

  assign error      = ErrWidth'(target_q) - ErrWidth'(measured_q);
  assign error_diff = (ErrWidth+1)'(error) - (ErrWidth+1)'(last_error_q);

  pidaw_scale #(.OperandWidth(ErrWidth)) u_scale_p (
    .gain_i    (gain_p_q),
    .operand_i (error),
    .term_o    (p_raw)
  );

  pidaw_scale #(.OperandWidth(ErrWidth)) u_scale_i (
    .gain_i    (gain_i_q),
    .operand_i (error),
    .term_o    (i_raw)
  );

  pidaw_scale #(.OperandWidth(ErrWidth+1)) u_scale_d (
    .gain_i    (gain_d_q),
    .operand_i (error_diff),
    .term_o    (d_raw)
  );

  assign in_band = (last_cmd_q > out_low_q) && (last_cmd_q < out_high_q);

  always_comb begin
    p_term = DataWidth'(clamp(SumWidth'(p_raw), SumWidth'(P_TERM_MIN), SumWidth'(P_TERM_MAX)));

    int_sum = in_band ? sat_data((DataWidth+1)'(integral_q) + (DataWidth+1)'(i_raw))
                      : integral_q;

    if (kind_e'(kind_q) == KIND_CLEAR) begin
      integral_d = '0;
    end else if (gain_i_q > 0) begin
      integral_d = DataWidth'(clamp(SumWidth'(int_sum), SumWidth'(int_low_q),
                                    SumWidth'(int_high_q)));
    end else begin
      integral_d = '0;
    end

    if (gain_d_q > 0) begin
      d_term = DataWidth'(clamp(SumWidth'(d_raw), SumWidth'(D_TERM_MIN), SumWidth'(D_TERM_MAX)));
    end else begin
      d_term = '0;
    end

    total = SumWidth'(p_term) + SumWidth'(integral_d) + SumWidth'(d_term);

    if (kind_e'(kind_q) == KIND_CLEAR) begin
      last_error_d = '0;
      last_cmd_d   = '0;
    end else begin
      last_error_d = error;
      last_cmd_d   = DataWidth'(clamp(total, SumWidth'(out_low_q), SumWidth'(out_high_q)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      integral_q   <= '0;
      last_cmd_q   <= '0;
    end else if (advance) begin
      last_error_q <= last_error_d;
      integral_q   <= integral_d;
      last_cmd_q   <= last_cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      command_q <= last_cmd_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pidaw_scale.sv =====
// Gain scaling for one PID term: Q8.8 gain times a signed operand,
// floor shift by the fraction bits, saturation to signed 16 bits.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_scale import pidaw_pkg::*; #(
  parameter int unsigned OperandWidth = 17
) (
  input  logic signed [DataWidth-1:0]    gain_i,
  input  logic signed [OperandWidth-1:0] operand_i,
  output logic signed [DataWidth-1:0]    term_o
);

  localparam int unsigned ProdWidth = DataWidth + OperandWidth;

  logic signed [ProdWidth-1:0] product;
  logic signed [ProdWidth-1:0] shifted;
  logic [ProdWidth-DataWidth:0] upper;

  assign product = ProdWidth'(gain_i) * ProdWidth'(operand_i);
  assign shifted = product >>> FracBits;
  assign upper   = shifted[ProdWidth-1:DataWidth-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      term_o = shifted[DataWidth-1:0];
    end else if (shifted[ProdWidth-1]) begin
      term_o = {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      term_o = {1'b0, {(DataWidth-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/pid_controller_antiwindup_test.sv =====
// Self-checking testbench for the anti-windup PID controller (pid_controller_antiwindup).
// Predicts each command from a local model of the gains, limits and controller state.
// Depends on pidaw_pkg and the controller RTL.
`timescale 1ns / 1ps

module pid_controller_antiwindup_test;
  import pidaw_pkg::*;

  localparam longint P_TERM_MIN = -32768;
  localparam longint P_TERM_MAX = 32767;
  localparam longint D_TERM_MIN = -32768;
  localparam longint D_TERM_MAX = 32767;
  localparam logic [CfgIdxWidth-1:0] CfgSpare = 3'd7;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxWidth-1:0]      cfg_index_i = '0;
  logic [DataWidth-1:0]        cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i = 1'b0;
  logic signed [DataWidth-1:0] target_i = '0;
  logic signed [DataWidth-1:0] measured_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DataWidth-1:0] command_o;

  // model copy of the registers and controller state
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic signed [15:0] int_lo, int_hi, out_lo, out_hi;
  logic signed [16:0] last_err;
  logic signed [15:0] integ, last_cmd;

  logic signed [15:0] pending_commands[$];
  logic signed [15:0] wanted_command;
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  pid_controller_antiwindup u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_commands.size() == 0) begin
        $error("command: expected none, actual %0d", command_o);
        mismatch_count++;
      end else begin
        wanted_command = pending_commands.pop_front();
        if (command_o !== wanted_command) begin
          $error("command: expected %0d, actual %0d", wanted_command, command_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint scale_q8(longint gain, longint v);
    return clip((gain * v) >>> 8, -32768, 32767);
  endfunction

  function automatic void reset_model();
    gain_p = '0;
    gain_i = '0;
    gain_d = '0;
    int_lo = 16'sh8000;
    int_hi = 16'sh7fff;
    out_lo = 16'sh8000;
    out_hi = 16'sh7fff;
    last_err = '0;
    integ = '0;
    last_cmd = '0;
  endfunction

  function automatic void apply_register(logic [CfgIdxWidth-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_GAIN_P:        gain_p = val;
      CFG_GAIN_I:        gain_i = val;
      CFG_GAIN_D:        gain_d = val;
      CFG_INTEGRAL_LOW:  int_lo = val;
      CFG_INTEGRAL_HIGH: int_hi = val;
      CFG_OUTPUT_LOW:    out_lo = val;
      CFG_OUTPUT_HIGH:   out_hi = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_command(kind_e k, logic signed [15:0] tgt,
                                          logic signed [15:0] meas);
    longint err, p, acc, d, cmd;
    if (k == KIND_CLEAR) begin
      last_err = '0;
      integ = '0;
      last_cmd = '0;
      pending_commands.push_back('0);
    end else begin
      err = longint'(tgt) - longint'(meas);
      p = clip(scale_q8(gain_p, err), P_TERM_MIN, P_TERM_MAX);
      acc = integ;
      if (gain_i > 0) begin
        if (last_cmd > out_lo && last_cmd < out_hi)
          acc = clip(acc + scale_q8(gain_i, err), -32768, 32767);
        acc = clip(acc, int_lo, int_hi);
      end else begin
        acc = 0;
      end
      d = 0;
      if (gain_d > 0) d = clip(scale_q8(gain_d, err - last_err), D_TERM_MIN, D_TERM_MAX);
      cmd = clip(p + acc + d, out_lo, out_hi);
      last_err = 17'(err);
      integ = 16'(acc);
      last_cmd = 16'(cmd);
      pending_commands.push_back(16'(cmd));
    end
  endfunction

  // hold off until every expected command has been transferred
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_commands.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_settings(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                               logic [15:0] il, logic [15:0] ih,
                               logic [15:0] ol, logic [15:0] oh);
    wait_drained();
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_INTEGRAL_LOW, il);
    write_reg(CFG_INTEGRAL_HIGH, ih);
    write_reg(CFG_OUTPUT_LOW, ol);
    write_reg(CFG_OUTPUT_HIGH, oh);
  endtask

  task automatic send_item(kind_e k, logic signed [15:0] tgt, logic signed [15:0] meas);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = k;
    target_i = tgt;
    measured_i = meas;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(k, tgt, meas);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'h0001;
        endcase
      end
      1: return 16'($urandom);
      5: return 16'(-int'($urandom_range(0, 1024)));
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic rand_limits(output logic signed [15:0] lo, output logic signed [15:0] hi);
    logic signed [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    if (a > b) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
    case ($urandom_range(0, 9))
      0: begin
        lo = 16'sh8000;
        hi = 16'sh7fff;
      end
      1: begin
        a = lo;
        lo = hi;
        hi = a;
      end
      2: hi = lo;
      3, 4, 5, 6: begin
        lo = 16'(-int'($urandom_range(0, 8192)));
        hi = 16'($urandom_range(0, 8192));
      end
      default: ;
    endcase
  endtask

  task automatic randomise_settings();
    logic signed [15:0] il, ih, ol, oh;
    rand_limits(il, ih);
    rand_limits(ol, oh);
    load_settings(rand_gain(), rand_gain(), rand_gain(), il, ih, ol, oh);
    if ($urandom_range(0, 1)) write_reg(CfgSpare, 16'($urandom));
  endtask

  task automatic random_item();
    kind_e              k;
    logic signed [15:0] tgt, meas;
    k = ($urandom_range(0, 99) < 4) ? KIND_CLEAR : KIND_STEP;
    tgt = 16'($urandom);
    meas = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: meas = 16'(int'(tgt) + int'($urandom_range(0, 1024)) - 512);
      4: begin
        tgt = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        meas = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      5: meas = tgt;
      default: ;
    endcase
    send_item(k, tgt, meas);
  endtask

  task automatic test_reset_state();
    send_item(KIND_STEP, 16'sh7fff, 16'sh8000);
    send_item(KIND_CLEAR, 16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_proportional();
    load_settings(16'h0100, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(KIND_STEP, 16'sh7fff, 16'sh8000);
    send_item(KIND_STEP, 16'sh8000, 16'sh7fff);
    send_item(KIND_STEP, 16'sh0000, 16'sh0000);
    send_item(KIND_STEP, 16'sh0080, 16'sh0000);
    load_settings(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(KIND_STEP, 16'sh7fff, 16'sh8000);
  endtask

  task automatic test_integral_windup();
    load_settings(16'h0000, 16'h0080, 16'h0000, -16'sd512, 16'sd512, -16'sd1000, 16'sd1000);
    repeat (4) send_item(KIND_STEP, 16'sh0100, 16'sh0000);
    // freeze the integral once the command sits on the upper limit
    load_settings(16'h0000, 16'h0080, 16'h0000, -16'sd512, 16'sd512, -16'sd1000, 16'sd300);
    repeat (2) send_item(KIND_STEP, 16'sh0100, 16'sh0000);
    send_item(KIND_STEP, -16'sh0100, 16'sh0000);
  endtask

  task automatic test_derivative();
    load_settings(16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(KIND_STEP, 16'sh0000, 16'sh0000);
    send_item(KIND_STEP, 16'sd1000, 16'sh0000);
    send_item(KIND_STEP, 16'sd1000, 16'sh0000);
    send_item(KIND_STEP, 16'sh8000, 16'sh7fff);
    load_settings(16'h0000, 16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(KIND_STEP, 16'sd5000, 16'sh0000);
  endtask

  task automatic test_inverted_limits();
    load_settings(16'h0100, 16'h0100, 16'h0100, 16'sd1000, -16'sd1000, 16'sd100, -16'sd100);
    send_item(KIND_STEP, 16'sd2000, 16'sh0000);
    send_item(KIND_STEP, -16'sd2000, 16'sh0000);
  endtask

  task automatic test_spare_register();
    wait_drained();
    write_reg(CfgSpare, 16'h7fff);
    send_item(KIND_STEP, 16'sd300, 16'sh0000);
    send_item(KIND_CLEAR, 16'sh0000, 16'sh0000);
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int n_items);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int seg = 0; seg < 4; seg++) begin
      randomise_settings();
      for (int i = 0; i < n_items / 4; i++) begin
        if (seg == 1 && i == n_items / 8) wait_drained();
        random_item();
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    reset_model();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_proportional();
    test_integral_windup();
    test_derivative();
    test_inverted_limits();
    test_spare_register();
    test_random_traffic(18, 70, 432);
    test_random_traffic(70, 18, 432);
    test_random_traffic(0, 0, 432);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
